FILE: rtl/ic2d_pkg.sv
// ----------------------------------------------------------------------------
// ic2d_pkg
// Shared types and constants for the 2-D convolution core.
// ----------------------------------------------------------------------------
package ic2d_pkg;

    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_W     = 12;
    localparam int NUM_KROWS  = 5;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KROW0  = 3'd2;

    localparam logic [10:0] RESET_WIDTH  = 11'd640;
    localparam logic [10:0] RESET_HEIGHT = 11'd480;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } ic2d_tag_t;

endpackage

FILE: rtl/image_convolution_2d_core.sv
// ----------------------------------------------------------------------------
// image_convolution_2d_core
// Streaming 2-D convolution with line stores and a signed Q4.8 kernel.
//
//  channel   signals                                        direction
//  cfg       cfg_we, cfg_index, cfg_data                    in
//  pixel     pixel_valid, pixel_ready, pixel_in             in
//  result    out_valid, out_ready, pixel_out, out_row,
//            out_col, frame_done                            out
//
// One pixel per clock while pixel_ready is high; results are registered
// and queued. The line store is read and written once per pixel.
// An 8-entry result queue absorbs output stalls; pixel_ready drops when
// the queue plus results in flight could fill it.
// Reset clears position and control; the line store is not cleared.
// ----------------------------------------------------------------------------
module image_convolution_2d_core #(
    parameter int FILTER_SIDE = 3,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ic2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ic2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [7:0]                       pixel_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       pixel_out,
    output logic [9:0]                       out_row,
    output logic [9:0]                       out_col,
    output logic                             frame_done
);
    import ic2d_pkg::*;

    localparam int WIN   = 2 * ((FILTER_SIDE - 1) / 2) + 1;
    localparam int QD    = 8;
    localparam int QAW   = $clog2(QD);
    localparam int LAT   = 6;

    logic [10:0] width_reg, height_reg;
    logic [59:0] krow_reg [NUM_KROWS];
    logic        in_fire;
    logic        win_valid;
    logic [WIN*WIN*8-1:0] win_pixels;
    ic2d_tag_t   win_tag, res_tag, q_tag;
    logic        res_valid;
    logic [7:0]  res_pixel;
    logic [QAW:0] q_count;
    logic [LAT-1:0] fly_reg;
    logic [3:0]  inflight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            for (int i = 0; i < NUM_KROWS; i++)
                krow_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data[10:0];
            else if (cfg_index == REG_HEIGHT)
                height_reg <= cfg_data[10:0];
            else if (cfg_index >= REG_KROW0 &&
                     cfg_index < REG_KROW0 + CFG_IDX_W'(NUM_KROWS))
                krow_reg[cfg_index - REG_KROW0] <= cfg_data;
        end
    end

    always_comb
    begin
        inflight = '0;
        for (int i = 0; i < LAT; i++)
            inflight = inflight + 4'(fly_reg[i]);
    end

    assign pixel_ready = (4'(q_count) + inflight) < 4'(QD);
    assign in_fire     = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fly_reg <= '0;
        else
            fly_reg <= {fly_reg[LAT-2:0], in_fire};
    end

    ic2d_front #(.WIN(WIN), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .in_fire      (in_fire),
        .pixel_in     (pixel_in),
        .win_valid    (win_valid),
        .win_pixels   (win_pixels),
        .win_tag      (win_tag)
    );

    ic2d_back #(.WIN(WIN)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .krow      (krow_reg),
        .in_valid  (win_valid),
        .in_pixels (win_pixels),
        .in_tag    (win_tag),
        .res_valid (res_valid),
        .res_pixel (res_pixel),
        .res_tag   (res_tag)
    );

    ic2d_queue #(.DEPTH(QD)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (res_valid),
        .wr_pixel  (res_pixel),
        .wr_tag    (res_tag),
        .count     (q_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (pixel_out),
        .out_tag   (q_tag)
    );

    assign out_row    = q_tag.row;
    assign out_col    = q_tag.col;
    assign frame_done = q_tag.last;

endmodule

FILE: rtl/ic2d_front.sv
// ----------------------------------------------------------------------------
// ic2d_front
// Position tracking, line store and window capture; classifies each pixel.
// ----------------------------------------------------------------------------
module ic2d_front #(
    parameter int WIN       = 3,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [10:0]             image_width,
    input  logic [10:0]             image_height,
    input  logic                    in_fire,
    input  logic [7:0]              pixel_in,
    output logic                    win_valid,
    output logic [WIN*WIN*8-1:0]    win_pixels,
    output ic2d_pkg::ic2d_tag_t     win_tag
);
    import ic2d_pkg::*;

    localparam int HALF  = (WIN - 1) / 2;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int SLOT_W = (WIN > 1) ? $clog2(WIN) : 1;

    logic [10:0] w_eff;
    logic [10:0] h_eff;
    logic [10:0] row_reg, row_next, col_reg, col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0] line_mem [WIN][MAX_WIDTH];
    logic [7:0] rd_reg [WIN];
    logic [7:0] pix_d_reg;
    logic [SLOT_W-1:0] slot_d_reg;
    logic [7:0] shift_reg [WIN][WIN];
    logic       s1_valid_reg;
    logic       s1_emit_reg;
    ic2d_tag_t  s1_tag_reg;
    logic       s2_valid_reg;
    ic2d_tag_t  s2_tag_reg;
    logic       emit;
    logic       in_col;

    always_comb
    begin
        w_eff = (image_width == 11'd0) ? 11'd1 : image_width;
        if (int'(w_eff) > MAX_WIDTH)
            w_eff = 11'(MAX_WIDTH);
        h_eff = (image_height == 11'd0) ? 11'd1 : image_height;
        if (h_eff > 11'(MAX_HEIGHT))
            h_eff = 11'(MAX_HEIGHT);
    end

    assign in_col = int'(col_reg) < MAX_WIDTH;
    assign emit = (row_reg < h_eff) && (col_reg < w_eff) &&
                  (row_reg >= 11'(2*HALF)) && (col_reg >= 11'(2*HALF));

    always_comb
    begin
        col_next  = col_reg + 11'd1;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (col_next >= w_eff)
        begin
            col_next = 11'd0;
            row_next = row_reg + 11'd1;
            slot_next = (slot_reg == SLOT_W'(WIN-1)) ? '0 : slot_reg + 1'b1;
            if (row_next >= h_eff)
            begin
                row_next  = 11'd0;
                slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (in_fire)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                slot_reg <= slot_next;
            end
        end
    end

    // read the column of older rows, write the new pixel
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int s = 0; s < WIN; s++)
            begin
                if (in_col)
                    rd_reg[s] <= line_mem[s][COL_W'(col_reg)];
            end
            if (in_col)
                line_mem[slot_reg][COL_W'(col_reg)] <= pixel_in;
            pix_d_reg   <= pixel_in;
            slot_d_reg  <= slot_reg;
            s1_emit_reg <= emit;
            s1_tag_reg.row  <= 10'(row_reg - 11'(HALF));
            s1_tag_reg.col  <= 10'(col_reg - 11'(HALF));
            s1_tag_reg.last <= (row_reg == h_eff - 11'd1) && (col_reg == w_eff - 11'd1);
        end
    end

    // row a=0 is the current row; a rows back uses slot-a
    always_ff @(posedge clk)
    begin
        logic [SLOT_W:0] rs;
        if (s1_valid_reg)
        begin
            for (int a = 0; a < WIN; a++)
            begin
                for (int b = WIN - 1; b > 0; b--)
                    shift_reg[a][b] <= shift_reg[a][b-1];
                rs = {1'b0, slot_d_reg} + (SLOT_W+1)'(WIN - a);
                if (rs >= (SLOT_W+1)'(WIN))
                    rs = rs - (SLOT_W+1)'(WIN);
                if (a == 0)
                    shift_reg[a][0] <= pix_d_reg;
                else
                    shift_reg[a][0] <= rd_reg[rs[SLOT_W-1:0]];
            end
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_comb
    begin
        for (int a = 0; a < WIN; a++)
            for (int b = 0; b < WIN; b++)
                win_pixels[(a*WIN+b)*8 +: 8] = shift_reg[a][b];
    end

    assign win_valid = s2_valid_reg;
    assign win_tag   = s2_tag_reg;

endmodule

FILE: rtl/ic2d_back.sv
// ----------------------------------------------------------------------------
// ic2d_back
// Multiply-accumulate pipeline, rounding toward zero and clamp.
// ----------------------------------------------------------------------------
module ic2d_back #(
    parameter int WIN = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [59:0]             krow [5],
    input  logic                    in_valid,
    input  logic [WIN*WIN*8-1:0]    in_pixels,
    input  ic2d_pkg::ic2d_tag_t     in_tag,
    output logic                    res_valid,
    output logic [7:0]              res_pixel,
    output ic2d_pkg::ic2d_tag_t     res_tag
);
    import ic2d_pkg::*;

    localparam int N     = WIN * WIN;
    localparam int SUM_W = 21 + $clog2(N + 1);

    logic signed [20:0] prod_reg [N];
    logic signed [SUM_W-1:0] row_sum_reg [WIN];
    logic signed [SUM_W-1:0] total;
    logic [2:0] v_reg;
    ic2d_tag_t  t1_reg, t2_reg;
    logic [7:0] res_reg;
    ic2d_tag_t  t3_reg;

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < WIN; a++)
            for (int b = 0; b < WIN; b++)
                prod_reg[a*WIN+b] <= $signed(krow[a][12*b +: 12]) *
                                     $signed({1'b0, in_pixels[(a*WIN+b)*8 +: 8]});
        t1_reg <= in_tag;
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < WIN; a++)
        begin
            logic signed [SUM_W-1:0] acc;
            acc = '0;
            for (int b = 0; b < WIN; b++)
                acc = acc + SUM_W'(prod_reg[a*WIN+b]);
            row_sum_reg[a] <= acc;
        end
        t2_reg <= t1_reg;
    end

    always_comb
    begin
        total = '0;
        for (int a = 0; a < WIN; a++)
            total = total + row_sum_reg[a];
    end

    always_ff @(posedge clk)
    begin
        if (total < 0)
            res_reg <= 8'd0;
        else if (total[SUM_W-1:8] > 255)
            res_reg <= 8'd255;
        else
            res_reg <= total[15:8];
        t3_reg <= t2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], in_valid};
    end

    assign res_valid = v_reg[2];
    assign res_pixel = res_reg;
    assign res_tag   = t3_reg;

endmodule

FILE: rtl/ic2d_queue.sv
// ----------------------------------------------------------------------------
// ic2d_queue
// Result queue between the pipeline and the output handshake.
// ----------------------------------------------------------------------------
module ic2d_queue #(
    parameter int DEPTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [7:0]              wr_pixel,
    input  ic2d_pkg::ic2d_tag_t     wr_tag,
    output logic [$clog2(DEPTH):0]  count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_pixel,
    output ic2d_pkg::ic2d_tag_t     out_tag
);
    import ic2d_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]      pix_mem [DEPTH];
    ic2d_tag_t       tag_mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            rd;

    assign out_valid = cnt_reg != '0;
    assign rd        = out_valid && out_ready;
    assign out_pixel = pix_mem[rp_reg];
    assign out_tag   = tag_mem[rp_reg];
    assign count     = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pix_mem[wp_reg] <= wr_pixel;
            tag_mem[wp_reg] <= wr_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == (AW+1)'(DEPTH) |-> !wr_en || rd)
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("result queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd && !wr_en |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("result queue count lost a read");

endmodule

FILE: tb/image_convolution_2d_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_convolution_2d_core_tb
// Streams whole frames through the 3x3 convolution core under several image
// sizes and kernels, with random gaps on the pixel side and random stalls on
// the result side. A local predictor keeps its own line store and position
// counters and checks every result word in order.
// ----------------------------------------------------------------------------
module image_convolution_2d_core_tb;

    import ic2d_pkg::*;

    localparam int SIDE  = 3;
    localparam int MAXW  = 1024;

    typedef struct {
        logic [7:0] pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } conv_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    logic [7:0]            pixel_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            pixel_out;
    logic [9:0]            out_row;
    logic [9:0]            out_col;
    logic                  frame_done;

    // predictor state
    logic [10:0]           cur_width = RESET_WIDTH;
    logic [10:0]           cur_height = RESET_HEIGHT;
    logic [CFG_DATA_W-1:0] kernel_rows [NUM_KROWS];
    logic [7:0]            row_lines [SIDE*MAXW];
    int unsigned           pos_row = 0;
    int unsigned           pos_col = 0;

    conv_word_t            pending_results [$];
    int                    error_count = 0;
    int                    pixels_sent = 0;
    int                    results_checked = 0;
    int                    frames_run = 0;
    bit                    no_idle = 1'b0;
    bit                    result_taken = 1'b0;

    always #5 clk = ~clk;

    image_convolution_2d_core #(
        .FILTER_SIDE(SIDE),
        .MAX_WIDTH  (MAXW)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_done (frame_done)
    );

    function automatic int unsigned eff_width();
        int unsigned w;
        w = cur_width;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = cur_height;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic longint coef_at(int a, int b);
        logic signed [COEF_W-1:0] raw;
        raw = kernel_rows[a][COEF_W*b +: COEF_W];
        return longint'(raw);
    endfunction

    task automatic convolve_pixel(input logic [7:0] p);
        int unsigned w, h, r, c, slot, rs;
        longint      sum;
        conv_word_t  wd;
        w = eff_width();
        h = eff_height();
        r = pos_row;
        c = pos_col;
        slot = r % SIDE;
        if (c < MAXW) row_lines[slot*MAXW + c] = p;
        if (r < h && c < w && r >= SIDE-1 && c >= SIDE-1) begin
            sum = 0;
            for (int a = 0; a < SIDE; a++) begin
                rs = (slot + SIDE - a) % SIDE;
                for (int b = 0; b < SIDE; b++)
                    sum += coef_at(a, b) * longint'(row_lines[rs*MAXW + c - b]);
            end
            if (sum < 0) wd.pix = 8'd0;
            else if ((sum >>> 8) > 255) wd.pix = 8'd255;
            else wd.pix = 8'(sum >>> 8);
            wd.row  = 10'(r - 1);
            wd.col  = 10'(c - 1);
            wd.last = (r == h - 1 && c == w - 1);
            pending_results.push_back(wd);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endtask

    // accept monitor and result checker
    always @(posedge clk) begin
        conv_word_t ew;
        result_taken <= out_valid && out_ready;
        if (out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word row=%0d col=%0d", out_row, out_col);
                error_count++;
            end else begin
                ew = pending_results.pop_front();
                results_checked++;
                if (pixel_out !== ew.pix) begin
                    $error("pixel_out exp=%0d act=%0d", ew.pix, pixel_out);
                    error_count++;
                end
                if (out_row !== ew.row) begin
                    $error("out_row exp=%0d act=%0d", ew.row, out_row);
                    error_count++;
                end
                if (out_col !== ew.col) begin
                    $error("out_col exp=%0d act=%0d", ew.col, out_col);
                    error_count++;
                end
                if (frame_done !== ew.last) begin
                    $error("frame_done exp=%0d act=%0d", ew.last, frame_done);
                    error_count++;
                end
            end
        end
        if (pixel_valid && pixel_ready && rst_n)
            convolve_pixel(pixel_in);
    end

    // result side stalls
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(negedge clk); while (!result_taken);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_WIDTH) cur_width = val[10:0];
        else if (idx == REG_HEIGHT) cur_height = val[10:0];
        else kernel_rows[idx - REG_KROW0] = val;
    endtask

    task automatic send_pixel(input logic [7:0] p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge clk);
            pixel_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel_in    <= p;
        do @(posedge clk); while (!pixel_ready);
        pixels_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // pattern 0 random, 1 extremes only, 2 ramp
    task automatic run_frame(input int pattern);
        int unsigned n;
        logic [7:0]  p;
        n = eff_width() * eff_height();
        for (int unsigned i = 0; i < n; i++) begin
            case (pattern)
                1:       p = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                2:       p = 8'(i);
                default: p = 8'($urandom);
            endcase
            send_pixel(p);
        end
        frames_run++;
        drain();
    endtask

    task automatic set_kernel(input logic [COEF_W-1:0] k [SIDE][SIDE]);
        logic [CFG_DATA_W-1:0] v;
        for (int a = 0; a < SIDE; a++) begin
            v = '0;
            for (int b = 0; b < SIDE; b++) v[COEF_W*b +: COEF_W] = k[a][b];
            cfg_write(CFG_IDX_W'(REG_KROW0 + a), v);
        end
    endtask

    task automatic set_uniform(input logic [COEF_W-1:0] c);
        logic [COEF_W-1:0] k [SIDE][SIDE];
        foreach (k[a, b]) k[a][b] = c;
        set_kernel(k);
    endtask

    task automatic set_random_kernel();
        logic [COEF_W-1:0] k [SIDE][SIDE];
        foreach (k[a, b]) k[a][b] = 12'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 96));
        set_kernel(k);
    endtask

    task automatic set_size(input logic [10:0] w, input logic [10:0] h);
        cfg_write(REG_WIDTH, {49'd0, w});
        cfg_write(REG_HEIGHT, {49'd0, h});
    endtask

    task automatic test_identity();
        logic [COEF_W-1:0] k [SIDE][SIDE];
        foreach (k[a, b]) k[a][b] = '0;
        k[1][1] = 12'h100;
        set_kernel(k);
        cfg_write(CFG_IDX_W'(REG_KROW0 + 3), {CFG_DATA_W{1'b1}});
        cfg_write(CFG_IDX_W'(REG_KROW0 + 4), 60'h0123456789ABCDE);
        set_size(11'd5, 11'd4);
        run_frame(1);
        set_size(11'd4, 11'd3);
        run_frame(2);
    endtask

    task automatic test_kernel_extremes();
        set_size(11'd4, 11'd4);
        set_uniform(12'h7FF);
        run_frame(1);
        set_uniform(12'h800);
        run_frame(1);
        set_uniform(12'hFFF);
        run_frame(0);
        set_uniform(12'd28);
        run_frame(0);
    endtask

    task automatic test_degenerate_sizes();
        set_random_kernel();
        set_size(11'd0, 11'd0);
        run_frame(0);
        set_size(11'd2, 11'd5);
        run_frame(0);
        set_size(11'd7, 11'd1);
        run_frame(0);
        set_size(11'd3, 11'd3);
        run_frame(0);
    endtask

    task automatic test_random_frames();
        int sent0;
        sent0 = pixels_sent;
        while (pixels_sent - sent0 < 700) begin
            no_idle = ($urandom_range(0, 3) == 0);
            set_random_kernel();
            set_size(11'($urandom_range(3, 14)), 11'($urandom_range(3, 9)));
            run_frame(0);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        foreach (kernel_rows[i]) kernel_rows[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_identity();
        test_kernel_extremes();
        test_degenerate_sizes();
        test_random_frames();
        $display("ran %0d frames, %0d pixels in, %0d result words checked",
                 frames_run, pixels_sent, results_checked);
        if (error_count == 0 && pending_results.size() == 0)
            $display("image_convolution_2d_core_tb: clean");
        else
            $display("image_convolution_2d_core_tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d result words outstanding", pending_results.size());
        $display("image_convolution_2d_core_tb: errors");
        $finish;
    end

endmodule
